>>> rtl/led_flash_brightness_driver_defines.svh
// assertion macros for the led flash brightness driver
// expects clk_i and rst_ni in the scope of each use
`ifndef LED_FLASH_BRIGHTNESS_DRIVER_DEFINES_SVH
`define LED_FLASH_BRIGHTNESS_DRIVER_DEFINES_SVH

// condition implies consequence in the same cycle
`define LFBD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lfbd assertion failed");

// condition implies consequence in the next cycle
`define LFBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lfbd assertion failed");

`endif

>>> rtl/lfbd_pkg.sv
// shared types, constants and codes of the led flash brightness driver
// no dependencies
package lfbd_pkg;

  // request opcodes
  typedef enum logic {
    OP_SET  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  localparam int unsigned ColorW  = 24;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned LenW    = 31;
  localparam int unsigned LevelW  = 16;

  localparam logic [7:0] LumaR = 8'd77;
  localparam logic [7:0] LumaG = 8'd150;
  localparam logic [7:0] LumaB = 8'd29;

  localparam logic [LevelW-1:0] PeakLevelRst = 16'd255;

  // one registered request
  typedef struct packed {
    op_e                       op;
    logic [ColorW-1:0]         color;
    logic                      flash_enable;
    logic signed [TimeW-1:0]   flash_on_ms;
    logic signed [TimeW-1:0]   flash_off_ms;
  } req_t;

endpackage

>>> rtl/lfbd_intf.sv
// request and result channel interfaces with valid/ready handshake
// depends on lfbd_pkg
interface lfbd_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 op;
  logic [lfbd_pkg::ColorW-1:0]          color;
  logic                                 flash_enable;
  logic signed [lfbd_pkg::TimeW-1:0]    flash_on_ms;
  logic signed [lfbd_pkg::TimeW-1:0]    flash_off_ms;

  modport source (output valid, op, color, flash_enable, flash_on_ms, flash_off_ms,
                  input ready);
  modport sink   (input valid, op, color, flash_enable, flash_on_ms, flash_off_ms,
                  output ready);
endinterface

interface lfbd_res_if;
  logic                                 valid;
  logic                                 ready;
  logic [lfbd_pkg::LevelW-1:0]          brightness;
  logic                                 flash_rejected;
  logic                                 flashing;

  modport source (output valid, brightness, flash_rejected, flashing, input ready);
  modport sink   (input valid, brightness, flash_rejected, flashing, output ready);
endinterface

>>> rtl/lfbd_luma.sv
// rgb to brightness: weighted luma sum, clamp and the special colours 0 and 1
// depends on lfbd_pkg
module lfbd_luma (
  input  logic [lfbd_pkg::ColorW-1:0] color_i,
  input  logic [lfbd_pkg::LevelW-1:0] peak_level_i,
  output logic [lfbd_pkg::LevelW-1:0] level_o
);

  logic [15:0] prod_r;
  logic [15:0] prod_g;
  logic [15:0] prod_b;
  logic [17:0] sum;
  logic [lfbd_pkg::LevelW-1:0] luma;

  // weighted sum, bits 17:8 kept
  assign prod_r = 16'(color_i[23:16]) * 16'(lfbd_pkg::LumaR);
  assign prod_g = 16'(color_i[15:8])  * 16'(lfbd_pkg::LumaG);
  assign prod_b = 16'(color_i[7:0])   * 16'(lfbd_pkg::LumaB);
  assign sum    = 18'(prod_r) + 18'(prod_g) + 18'(prod_b);
  assign luma   = lfbd_pkg::LevelW'(sum[17:8]);

  // colour 0 is off, colour 1 is full, others clamp
  always_comb begin
    if (color_i == lfbd_pkg::ColorW'(0)) begin
      level_o = '0;
    end else if (color_i == lfbd_pkg::ColorW'(1)) begin
      level_o = peak_level_i;
    end else if (luma > peak_level_i) begin
      level_o = peak_level_i;
    end else begin
      level_o = luma;
    end
  end

endmodule

>>> rtl/lfbd_input_stage.sv
// input register: holds one request until the core takes it
// depends on lfbd_pkg and lfbd_req_if
module lfbd_input_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  lfbd_req_if.sink       req_i,
  input  logic           advance_i,
  output logic           stage_valid_o,
  output lfbd_pkg::req_t stage_req_o
);

  logic           valid_q;
  lfbd_pkg::req_t req_q;

  // free slot or slot draining this cycle
  assign req_i.ready = !valid_q || advance_i;

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      req_q.op           <= lfbd_pkg::op_e'(req_i.op);
      req_q.color        <= req_i.color;
      req_q.flash_enable <= req_i.flash_enable;
      req_q.flash_on_ms  <= req_i.flash_on_ms;
      req_q.flash_off_ms <= req_i.flash_off_ms;
    end
  end

  assign stage_valid_o = valid_q;
  assign stage_req_o   = req_q;

endmodule

>>> rtl/lfbd_core.sv
// flash state, phase countdown and result register
// depends on lfbd_pkg, lfbd_luma and lfbd_res_if
module lfbd_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        stage_valid_i,
  input  lfbd_pkg::req_t              stage_req_i,
  input  logic [lfbd_pkg::LevelW-1:0] peak_level_i,
  output logic                        advance_o,
  lfbd_res_if.source                  res_o
);

  localparam int unsigned LenW   = lfbd_pkg::LenW;
  localparam int unsigned LevelW = lfbd_pkg::LevelW;

  logic                         flash_active_q, flash_active_d;
  logic                         lit_phase_q, lit_phase_d;
  logic [lfbd_pkg::ColorW-1:0]  held_color_q, held_color_d;
  logic [LenW-1:0]              on_length_q, on_length_d;
  logic [LenW-1:0]              off_length_q, off_length_d;
  logic [LenW-1:0]              remaining_q, remaining_d;
  logic [LevelW-1:0]            level_q, level_d;
  logic                         rejected_d;

  logic                         res_valid_q;
  logic                         res_rejected_q;

  logic                         fire;
  logic                         is_set;
  logic                         bad_times;
  logic [lfbd_pkg::ColorW-1:0]  luma_color;
  logic [LevelW-1:0]            luma_level;

  // core moves when the result slot is free or being taken
  assign advance_o = !res_valid_q || res_o.ready;
  assign fire      = stage_valid_i && advance_o;
  assign is_set    = (stage_req_i.op == lfbd_pkg::OP_SET);

  // invalid flash times: either negative or both zero
  assign bad_times = stage_req_i.flash_on_ms[31] || stage_req_i.flash_off_ms[31] ||
                     ((stage_req_i.flash_on_ms == '0) && (stage_req_i.flash_off_ms == '0));

  // brightness of the new colour on a set request, of the held colour on a tick
  assign luma_color = is_set ? stage_req_i.color : held_color_q;

  lfbd_luma u_luma (
    .color_i      (luma_color),
    .peak_level_i (peak_level_i),
    .level_o      (luma_level)
  );

  // next state for one request
  always_comb begin
    flash_active_d = flash_active_q;
    lit_phase_d    = lit_phase_q;
    held_color_d   = held_color_q;
    on_length_d    = on_length_q;
    off_length_d   = off_length_q;
    remaining_d    = remaining_q;
    level_d        = level_q;
    rejected_d     = 1'b0;
    if (is_set) begin
      held_color_d   = stage_req_i.color;
      on_length_d    = stage_req_i.flash_on_ms[LenW-1:0];
      off_length_d   = stage_req_i.flash_off_ms[LenW-1:0];
      flash_active_d = 1'b0;
      lit_phase_d    = 1'b0;
      remaining_d    = '0;
      if (stage_req_i.flash_enable && bad_times) begin
        rejected_d = 1'b1;
      end else begin
        level_d = luma_level;
        if (stage_req_i.flash_enable) begin
          flash_active_d = 1'b1;
          lit_phase_d    = 1'b1;
          remaining_d    = stage_req_i.flash_on_ms[LenW-1:0];
        end
      end
    end else if (flash_active_q) begin
      if (remaining_q <= LenW'(1)) begin
        lit_phase_d = !lit_phase_q;
        if (!lit_phase_q) begin
          remaining_d = on_length_q;
          level_d     = luma_level;
        end else begin
          remaining_d = off_length_q;
          level_d     = '0;
        end
      end else begin
        remaining_d = remaining_q - LenW'(1);
      end
    end
  end

  // state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_active_q <= 1'b0;
      lit_phase_q    <= 1'b0;
      held_color_q   <= '0;
      on_length_q    <= '0;
      off_length_q   <= '0;
      remaining_q    <= '0;
      level_q        <= '0;
      res_valid_q    <= 1'b0;
      res_rejected_q <= 1'b0;
    end else begin
      if (advance_o) begin
        res_valid_q <= stage_valid_i;
      end
      if (fire) begin
        flash_active_q <= flash_active_d;
        lit_phase_q    <= lit_phase_d;
        held_color_q   <= held_color_d;
        on_length_q    <= on_length_d;
        off_length_q   <= off_length_d;
        remaining_q    <= remaining_d;
        level_q        <= level_d;
        res_rejected_q <= rejected_d;
      end
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.brightness     = level_q;
  assign res_o.flash_rejected = res_rejected_q;
  assign res_o.flashing       = flash_active_q;

endmodule

>>> rtl/led_flash_brightness_driver.sv
// channel   dir  modport  payload
// req_i     in   sink     op, color, flash_enable, flash_on_ms, flash_off_ms
// res_o     out  source   brightness, flash_rejected, flashing
// cfg       in   -        cfg_we_i, cfg_wdata_i (peak level)
//
// one request per cycle sustained while res_o.ready stays high; an accepted request passes the input register,
// then the single-pass state update into the result register, where res_o.valid shows it
// with res_o.ready low the block buffers two requests, then req_i.ready falls
// reset clears all flash state, the driven level and the result valid
// peak level resets to 255
//
// top level of the led flash brightness driver
// depends on lfbd_pkg, lfbd_intf, lfbd_input_stage, lfbd_core and the defines header
`include "led_flash_brightness_driver_defines.svh"

module led_flash_brightness_driver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lfbd_req_if.sink                    req_i,
  lfbd_res_if.source                  res_o,
  input  logic                        cfg_we_i,
  input  logic [lfbd_pkg::LevelW-1:0] cfg_wdata_i
);

  logic [lfbd_pkg::LevelW-1:0] peak_level_q;
  logic                        stage_valid;
  lfbd_pkg::req_t              stage_req;
  logic                        advance;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_level_q <= lfbd_pkg::PeakLevelRst;
    end else if (cfg_we_i) begin
      peak_level_q <= cfg_wdata_i;
    end
  end

  // input register
  lfbd_input_stage u_input_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .advance_i     (advance),
    .stage_valid_o (stage_valid),
    .stage_req_o   (stage_req)
  );

  // state update and result register
  lfbd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_valid_i (stage_valid),
    .stage_req_i   (stage_req),
    .peak_level_i  (peak_level_q),
    .advance_o     (advance),
    .res_o         (res_o)
  );

  // a rejected request never leaves the block flashing
  `LFBD_ASSERT_NOW(a_reject_stops_flash, res_o.valid && res_o.flash_rejected, !res_o.flashing)
  // a held request is not dropped while the core stalls
  `LFBD_ASSERT_NEXT(a_stage_holds, stage_valid && !advance, stage_valid)
  // a request taken by the core shows up as a result
  `LFBD_ASSERT_NEXT(a_fire_gives_result, stage_valid && advance, res_o.valid)

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// testbench for the led flash brightness driver: steady and flashing requests,
// invalid flash times, peak level settings and output stalls, checked by a local model
// depends on lfbd_pkg, lfbd_intf and the led_flash_brightness_driver rtl

module tb_top;

  localparam int unsigned LevelW = lfbd_pkg::LevelW;
  localparam int unsigned ColorW = lfbd_pkg::ColorW;
  localparam int unsigned LenW   = lfbd_pkg::LenW;
  localparam int unsigned TimeW  = lfbd_pkg::TimeW;

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned LongHold  = 300;
  localparam int unsigned DrainWait = 10;

  typedef struct packed {
    logic [LevelW-1:0] brightness;
    logic              flash_rejected;
    logic              flashing;
  } led_out_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [LevelW-1:0] cfg_wdata;

  lfbd_req_if req_if ();
  lfbd_res_if res_if ();

  led_flash_brightness_driver i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // model state of the led driver
  logic [LevelW-1:0] m_max_level  = lfbd_pkg::PeakLevelRst;
  logic              m_flashing   = 1'b0;
  logic              m_lit        = 1'b0;
  logic [ColorW-1:0] m_color      = '0;
  logic [LenW-1:0]   m_on_len     = '0;
  logic [LenW-1:0]   m_off_len    = '0;
  logic [LenW-1:0]   m_remaining  = '0;
  logic [LevelW-1:0] m_level      = '0;

  led_out_t    pending_outputs [$];
  led_out_t    got_out;
  led_out_t    want_out;
  int unsigned mismatch_count = 0;
  int unsigned n_requests     = 0;
  int unsigned n_results      = 0;
  int unsigned n_sets         = 0;
  int unsigned n_ticks        = 0;
  int unsigned n_flash_starts = 0;
  int unsigned n_rejects      = 0;
  int unsigned n_cfg_writes   = 0;
  int unsigned idle_cycles    = 0;
  int unsigned ready_hold     = 0;
  bit          stream_mode    = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // luma of a colour, clamped to the peak level
  function automatic logic [LevelW-1:0] luma_level(input logic [ColorW-1:0] c);
    int unsigned r, g, b, sum;
    r = 32'(c[23:16]);
    g = 32'(c[15:8]);
    b = 32'(c[7:0]);
    if (c > 1) begin
      sum = (32'(lfbd_pkg::LumaR) * r + 32'(lfbd_pkg::LumaG) * g +
             32'(lfbd_pkg::LumaB) * b) >> 8;
      if (sum > 32'(m_max_level)) sum = 32'(m_max_level);
      return sum[LevelW-1:0];
    end else if (c == 1) begin
      return m_max_level;
    end
    return '0;
  endfunction

  // one request through the driver state, giving the output it leaves behind
  function automatic led_out_t led_driver_step(input lfbd_pkg::req_t r);
    led_out_t o;
    logic     rej;
    rej = 1'b0;
    if (r.op == lfbd_pkg::OP_SET) begin
      n_sets++;
      m_flashing  = 1'b0;
      m_lit       = 1'b0;
      m_remaining = '0;
      m_color     = r.color;
      m_on_len    = r.flash_on_ms[LenW-1:0];
      m_off_len   = r.flash_off_ms[LenW-1:0];
      if (r.flash_enable) begin
        if (r.flash_on_ms[TimeW-1] || r.flash_off_ms[TimeW-1] ||
            (r.flash_on_ms == 0 && r.flash_off_ms == 0)) begin
          rej = 1'b1;
          n_rejects++;
        end else begin
          m_flashing  = 1'b1;
          m_lit       = 1'b1;
          m_remaining = m_on_len;
          m_level     = luma_level(m_color);
          n_flash_starts++;
        end
      end else begin
        m_level = luma_level(m_color);
      end
    end else begin
      n_ticks++;
      if (m_flashing) begin
        // phase ends on its last tick, or at once for a zero length
        if (m_remaining <= 1) begin
          m_lit = !m_lit;
          if (m_lit) begin
            m_remaining = m_on_len;
            m_level     = luma_level(m_color);
          end else begin
            m_remaining = m_off_len;
            m_level     = '0;
          end
        end else begin
          m_remaining = m_remaining - LenW'(1);
        end
      end
    end
    o.brightness     = m_level;
    o.flash_rejected = rej;
    o.flashing       = m_flashing;
    return o;
  endfunction

  // gap length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 90) return $urandom_range(1, 3);
    if (k < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // phase length: mostly a few ms
  function automatic int unsigned pick_len();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 10) return 0;
    if (k < 85) return $urandom_range(1, 6);
    if (k < 97) return $urandom_range(7, 40);
    return $urandom_range(41, 200);
  endfunction

  function automatic logic [ColorW-1:0] pick_color();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k == 0) return '0;
    if (k == 1) return 24'd1;
    if (k == 2) return 24'hFFFFFF;
    return ColorW'($urandom);
  endfunction

  function automatic lfbd_pkg::req_t set_req(input logic [ColorW-1:0] c, input logic fe,
                                             input logic signed [TimeW-1:0] on_ms,
                                             input logic signed [TimeW-1:0] off_ms);
    lfbd_pkg::req_t r;
    r.op           = lfbd_pkg::OP_SET;
    r.color        = c;
    r.flash_enable = fe;
    r.flash_on_ms  = on_ms;
    r.flash_off_ms = off_ms;
    return r;
  endfunction

  // tick with random content in the ignored fields
  function automatic lfbd_pkg::req_t tick_req();
    lfbd_pkg::req_t r;
    r.op           = lfbd_pkg::OP_TICK;
    r.color        = ColorW'($urandom);
    r.flash_enable = 1'($urandom_range(0, 1));
    r.flash_on_ms  = $urandom;
    r.flash_off_ms = $urandom;
    return r;
  endfunction

  function automatic lfbd_pkg::req_t noise_req();
    lfbd_pkg::req_t r;
    r              = tick_req();
    r.op           = lfbd_pkg::op_e'(1'($urandom_range(0, 1)));
    return r;
  endfunction

  function automatic logic [LevelW-1:0] max_setting(input int unsigned idx);
    case (idx)
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return 16'd1;
      3:       return 16'd100;
      4:       return LevelW'($urandom);
      default: return lfbd_pkg::PeakLevelRst;
    endcase
  endfunction

  // offer one request, record its expected output on acceptance
  task automatic send_request(input lfbd_pkg::req_t r);
    int unsigned gap;
    req_if.valid        <= 1'b1;
    req_if.op           <= r.op;
    req_if.color        <= r.color;
    req_if.flash_enable <= r.flash_enable;
    req_if.flash_on_ms  <= r.flash_on_ms;
    req_if.flash_off_ms <= r.flash_off_ms;
    do @(posedge clk_i); while (!req_if.ready);
    pending_outputs.push_back(led_driver_step(r));
    n_requests++;
    gap = stream_mode ? 0 : pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_all_results();
    req_if.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
  endtask

  // register write only with the block idle
  task automatic write_peak_level(input logic [LevelW-1:0] v);
    wait_all_results();
    repeat (3) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we      <= 1'b0;
    m_max_level = v;
    n_cfg_writes++;
  endtask

  task automatic report_mismatch(input led_out_t want, input led_out_t got, input bit orphan);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      if (orphan)
        $display("error: result with nothing pending: brightness %0d rejected %0b flashing %0b",
                 got.brightness, got.flash_rejected, got.flashing);
      else
        $display("error: result %0d: brightness exp %0d got %0d, rejected exp %0b got %0b, %s",
                 n_results, want.brightness, got.brightness, want.flash_rejected,
                 got.flash_rejected, $sformatf("flashing exp %0b got %0b",
                 want.flashing, got.flashing));
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      got_out.brightness     = res_if.brightness;
      got_out.flash_rejected = res_if.flash_rejected;
      got_out.flashing       = res_if.flashing;
      n_results++;
      if (pending_outputs.size() == 0) begin
        report_mismatch(got_out, got_out, 1'b1);
      end else begin
        want_out = pending_outputs.pop_front();
        if (got_out.brightness != want_out.brightness ||
            got_out.flash_rejected != want_out.flash_rejected ||
            got_out.flashing != want_out.flashing)
          report_mismatch(want_out, got_out, 1'b0);
      end
    end
  end

  // result side ready: random stalls, or a long hold-off on request
  initial begin : drive_result_ready
    int unsigned stall_left;
    stall_left   = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (ready_hold > 0) begin
        res_if.ready <= 1'b0;
        ready_hold--;
      end else begin
        if (stall_left == 0 && !stream_mode) stall_left = pick_gap();
        if (stall_left > 0) begin
          res_if.ready <= 1'b0;
          stall_left--;
        end else begin
          res_if.ready <= 1'b1;
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no handshake for %0d cycles, %0d results pending",
               idle_cycles, pending_outputs.size());
      $display("led_flash_brightness_driver: mismatch");
      $finish;
    end
  end

  // steady colours including the off and full-scale codes, then a tick
  task automatic test_steady_light();
    send_request(set_req(24'h000000, 1'b0, 32'sh80000000, 32'sd0));
    send_request(set_req(24'h000001, 1'b0, 32'sd0, 32'sd0));
    send_request(set_req(24'hFFFFFF, 1'b0, 32'sh7FFFFFFF, -32'sd1));
    send_request(set_req(24'hFF0000, 1'b0, 32'sd5, 32'sd5));
    send_request(set_req(24'h00FF00, 1'b0, 32'sd0, 32'sd1));
    send_request(set_req(24'h0000FF, 1'b0, 32'sd1, 32'sd0));
    send_request(set_req(24'h000002, 1'b0, 32'sd3, 32'sd3));
    send_request(tick_req());
  endtask

  // invalid times: level kept, flag raised, running flash stopped
  task automatic test_rejected_flash();
    send_request(set_req(24'hFFFFFF, 1'b1, -32'sd1, 32'sd5));
    send_request(set_req(24'h00FF00, 1'b1, 32'sd3, 32'sh80000000));
    send_request(set_req(24'h0000FF, 1'b1, 32'sd0, 32'sd0));
    send_request(set_req(24'h808080, 1'b1, 32'sd2, 32'sd2));
    send_request(tick_req());
    send_request(set_req(24'h123456, 1'b1, -32'sd5, 32'sd2));
    send_request(tick_req());
  endtask

  // zero-length phases, short phases and the longest phase
  task automatic test_flash_phases();
    send_request(set_req(24'h123456, 1'b1, 32'sd1, 32'sd0));
    repeat (4) send_request(tick_req());
    send_request(set_req(24'hA0B0C0, 1'b1, 32'sd0, 32'sd2));
    repeat (4) send_request(tick_req());
    send_request(set_req(24'h000001, 1'b1, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
    repeat (2) send_request(tick_req());
  endtask

  // long result hold-off fills the block, then the sender waits for all results
  task automatic test_output_stall();
    send_request(set_req(pick_color(), 1'b1, 32'sd2, 32'sd3));
    wait_all_results();
    ready_hold = LongHold;
    repeat (40) send_request(tick_req());
    wait_all_results();
  endtask

  // flash sequences with random content, steady sets, bad times and noise
  task automatic test_random_traffic(input int unsigned n);
    int unsigned start, idx, k, on_len, off_len, ticks;
    start = n_requests;
    idx   = 0;
    while (n_requests - start < n) begin
      if (idx < 6 && n_requests - start >= idx * n / 6) begin
        write_peak_level(max_setting(idx));
        idx++;
      end
      stream_mode = ($urandom_range(0, 9) == 0);
      k = $urandom_range(0, 99);
      if (k < 60) begin
        on_len  = pick_len();
        off_len = pick_len();
        if (on_len == 0 && off_len == 0) off_len = 1;
        send_request(set_req(pick_color(), 1'b1, on_len, off_len));
        ticks = $urandom_range(1, 2 * (on_len + off_len) + 4);
        if (ticks > 80) ticks = 80;
        repeat (ticks) send_request(tick_req());
      end else if (k < 75) begin
        send_request(set_req(pick_color(), 1'b0, $urandom, $urandom));
        repeat ($urandom_range(0, 3)) send_request(tick_req());
      end else if (k < 85) begin
        case ($urandom_range(0, 2))
          0:       send_request(set_req(pick_color(), 1'b1, $urandom | 32'h80000000, $urandom));
          1:       send_request(set_req(pick_color(), 1'b1, pick_len(),
                                        $urandom | 32'h80000000));
          default: send_request(set_req(pick_color(), 1'b1, 32'sd0, 32'sd0));
        endcase
        repeat ($urandom_range(0, 3)) send_request(tick_req());
      end else begin
        repeat ($urandom_range(1, 4)) send_request(noise_req());
      end
    end
    stream_mode = 1'b0;
  endtask

  // test sequence
  initial begin
    rst_ni              = 1'b0;
    req_if.valid        <= 1'b0;
    req_if.op           <= lfbd_pkg::OP_SET;
    req_if.color        <= '0;
    req_if.flash_enable <= 1'b0;
    req_if.flash_on_ms  <= '0;
    req_if.flash_off_ms <= '0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_steady_light();
    test_rejected_flash();
    test_flash_phases();
    test_output_stall();
    test_random_traffic(1150);

    wait_all_results();
    repeat (DrainWait) @(posedge clk_i);

    $display("covered %0d requests (%0d sets, %0d ticks): %0d flash starts, %0d bad flash times",
             n_requests, n_sets, n_ticks, n_flash_starts, n_rejects);
    $display("%0d results checked over %0d peak level writes, %0d errors, %0d left pending",
             n_results, n_cfg_writes, mismatch_count, pending_outputs.size());
    if (mismatch_count == 0 && pending_outputs.size() == 0) begin
      $display("led_flash_brightness_driver: match");
    end else begin
      $display("led_flash_brightness_driver: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/lfbd_pkg.sv
rtl/lfbd_intf.sv
rtl/lfbd_luma.sv
rtl/lfbd_input_stage.sv
rtl/lfbd_core.sv
rtl/led_flash_brightness_driver.sv
test/tb_top.sv
